/* src/scc_pkg.sv */
// ----------------------------------------------------------------------------
// scc_pkg: shared types and constants of the system control register unit
// Holds the transfer payload types, the register select codes and the
// coprocessor encodings used by the decoder and the register file.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

	// Sizes.
	localparam int WORD_W        = 32;
	localparam int DOMAIN_COUNT  = 16;
	localparam int DOMAIN_W      = 2;
	localparam int CONTEXT_COUNT = 5;
	localparam int CTX_IDX_W     = 3;
	localparam int CFG_IDX_W     = 3;
	localparam int FEATURE_COUNT = 4;

	// Reset values and fixed words.
	localparam logic [WORD_W-1:0] CONTROL_RESET    = 32'h0009_0078;
	localparam logic [WORD_W-1:0] TCM_STATUS       = 32'h0001_0001;
	localparam logic [WORD_W-1:0] ID_CODE_RESET    = 32'h4106_9265;
	localparam logic [WORD_W-1:0] CACHE_TYPE_RESET = 32'h1D11_2152;

	// Control word bit positions.
	localparam int CTRL_MMU_BIT    = 0;
	localparam int CTRL_DCACHE_BIT = 2;
	localparam int CTRL_ICACHE_BIT = 12;
	localparam int CTRL_HIVEC_BIT  = 13;

	// Primary register numbers.
	localparam logic [3:0] CRN_ID           = 4'd0;
	localparam logic [3:0] CRN_CONTROL      = 4'd1;
	localparam logic [3:0] CRN_TTB          = 4'd2;
	localparam logic [3:0] CRN_DOMAIN       = 4'd3;
	localparam logic [3:0] CRN_FAULT_STATUS = 4'd5;
	localparam logic [3:0] CRN_FAULT_ADDR   = 4'd6;
	localparam logic [3:0] CRN_CACHE        = 4'd7;
	localparam logic [3:0] CRN_TLB          = 4'd8;
	localparam logic [3:0] CRN_CONTEXT      = 4'd13;

	// Secondary register numbers.
	localparam logic [3:0] CRM_ID_MAIN    = 4'd0;
	localparam logic [3:0] CRM_FEATURE    = 4'd1;
	localparam logic [3:0] CRM_WFI        = 4'd0;
	localparam logic [3:0] CRM_INV_I      = 4'd5;
	localparam logic [3:0] CRM_INV_D      = 4'd6;
	localparam logic [3:0] CRM_INV_BOTH   = 4'd7;
	localparam logic [3:0] CRM_CLEAN      = 4'd10;
	localparam logic [3:0] CRM_TEST_CLEAN = 4'd14;
	localparam logic [3:0] CRM_CLEAN_INV  = 4'd15;
	localparam logic [3:0] CRM_TLB_FIRST  = 4'd5;
	localparam logic [3:0] CRM_TLB_LAST   = 4'd7;

	// Second opcode values.
	localparam logic [2:0] OPC2_0          = 3'd0;
	localparam logic [2:0] OPC2_1          = 3'd1;
	localparam logic [2:0] OPC2_2          = 3'd2;
	localparam logic [2:0] OPC2_3          = 3'd3;
	localparam logic [2:0] OPC2_4          = 3'd4;
	localparam logic [2:0] OPC2_5          = 3'd5;
	localparam logic [2:0] OPC2_6          = 3'd6;
	localparam logic [2:0] OPC2_7          = 3'd7;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ID_CODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CACHE_TYPE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MMF0       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MMF1       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MMF2       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MMF3       = 3'd5;

	// Stored register selected by a write.
	typedef enum logic [3:0] {
		SEL_CONTROL,
		SEL_AUX,
		SEL_TTB0,
		SEL_TTB1,
		SEL_TTBC,
		SEL_DOMAIN,
		SEL_DFSR,
		SEL_IFSR,
		SEL_FAR,
		SEL_CONTEXT
	} reg_sel_t;

	// Register write command from the decoder to the register file.
	typedef struct packed {
		logic                 en;
		reg_sel_t             sel;
		logic [CTX_IDX_W-1:0] ctx_idx;
		logic [WORD_W-1:0]    data;
	} reg_wr_t;

	// Current contents of the stored registers.
	typedef struct packed {
		logic [WORD_W-1:0]                    control_word;
		logic [WORD_W-1:0]                    aux_control_word;
		logic [WORD_W-1:0]                    table_base0;
		logic [WORD_W-1:0]                    table_base1;
		logic [WORD_W-1:0]                    table_control;
		logic [WORD_W-1:0]                    domain_word;
		logic [WORD_W-1:0]                    data_fault_status;
		logic [WORD_W-1:0]                    instr_fault_status;
		logic [WORD_W-1:0]                    fault_address;
		logic [CONTEXT_COUNT-1:0][WORD_W-1:0] context_words;
	} reg_view_t;

	// Current contents of the configuration words.
	typedef struct packed {
		logic [WORD_W-1:0]                    id_code;
		logic [WORD_W-1:0]                    cache_type;
		logic [FEATURE_COUNT-1:0][WORD_W-1:0] mem_model_feature;
	} cfg_view_t;

	// One coprocessor access.
	typedef struct packed {
		logic              action;
		logic [3:0]        primary_reg;
		logic [3:0]        secondary_reg;
		logic [2:0]        opc1;
		logic [2:0]        opc2;
		logic [WORD_W-1:0] write_data;
	} req_t;

	// Result of one access.
	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic              access_ok;
		logic              set_zero_flag;
		logic              access_error;
		logic              invalidate_icache;
		logic              invalidate_dcache;
		logic              mmu_on;
		logic              icache_on;
		logic              dcache_on;
		logic              high_vectors;
	} rsp_t;

endpackage

`default_nettype wire

/* src/scc_regfile.sv */
// ----------------------------------------------------------------------------
// scc_regfile: stored registers of the system control register unit
// Holds the control, translation, domain, fault and context registers and
// the configuration words, and presents their current contents.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_regfile
	import scc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire reg_wr_t              wr,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WORD_W-1:0]    cfg_data,
	output reg_view_t                 view,
	output cfg_view_t                 cfg
);

	logic [WORD_W-1:0]                         control_q;
	logic [WORD_W-1:0]                         aux_q;
	logic [WORD_W-1:0]                         ttb0_q;
	logic [WORD_W-1:0]                         ttb1_q;
	logic [WORD_W-1:0]                         ttbc_q;
	logic [DOMAIN_COUNT-1:0][DOMAIN_W-1:0]     domain_q;
	logic [WORD_W-1:0]                         dfsr_q;
	logic [WORD_W-1:0]                         ifsr_q;
	logic [WORD_W-1:0]                         far_q;
	logic [CONTEXT_COUNT-1:0][WORD_W-1:0]      context_q;
	logic [WORD_W-1:0]                         id_code_q;
	logic [WORD_W-1:0]                         cache_type_q;
	logic [FEATURE_COUNT-1:0][WORD_W-1:0]      mmf_q;

	// Architectural registers, written by a completed access.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q <= CONTROL_RESET;
			aux_q     <= '0;
			ttb0_q    <= '0;
			ttb1_q    <= '0;
			ttbc_q    <= '0;
			domain_q  <= '0;
			dfsr_q    <= '0;
			ifsr_q    <= '0;
			far_q     <= '0;
			context_q <= '0;
		end else if (wr.en) begin
			unique case (wr.sel)
				SEL_CONTROL: control_q <= wr.data;
				SEL_AUX:     aux_q     <= wr.data;
				SEL_TTB0:    ttb0_q    <= wr.data;
				SEL_TTB1:    ttb1_q    <= wr.data;
				SEL_TTBC:    ttbc_q    <= wr.data;
				SEL_DOMAIN: begin
					for (int i = 0; i < DOMAIN_COUNT; i++) begin
						domain_q[i] <= wr.data[DOMAIN_W*i +: DOMAIN_W];
					end
				end
				SEL_DFSR:    dfsr_q    <= wr.data;
				SEL_IFSR:    ifsr_q    <= wr.data;
				SEL_FAR:     far_q     <= wr.data;
				SEL_CONTEXT: begin
					for (int i = 0; i < CONTEXT_COUNT; i++) begin
						if (wr.ctx_idx == CTX_IDX_W'(i)) begin
							context_q[i] <= wr.data;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Configuration words; the user must write them only while the unit is idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_code_q    <= ID_CODE_RESET;
			cache_type_q <= CACHE_TYPE_RESET;
			mmf_q        <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ID_CODE:    id_code_q    <= cfg_data;
				CFG_CACHE_TYPE: cache_type_q <= cfg_data;
				CFG_MMF0:       mmf_q[0]     <= cfg_data;
				CFG_MMF1:       mmf_q[1]     <= cfg_data;
				CFG_MMF2:       mmf_q[2]     <= cfg_data;
				CFG_MMF3:       mmf_q[3]     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Present the contents; domain i sits at bits 2i+1..2i of the packed word.
	always_comb begin
		view.control_word       = control_q;
		view.aux_control_word   = aux_q;
		view.table_base0        = ttb0_q;
		view.table_base1        = ttb1_q;
		view.table_control      = ttbc_q;
		view.domain_word        = '0;
		for (int i = 0; i < DOMAIN_COUNT; i++) begin
			view.domain_word[DOMAIN_W*i +: DOMAIN_W] = domain_q[i];
		end
		view.data_fault_status  = dfsr_q;
		view.instr_fault_status = ifsr_q;
		view.fault_address      = far_q;
		view.context_words      = context_q;
		cfg.id_code             = id_code_q;
		cfg.cache_type          = cache_type_q;
		cfg.mem_model_feature   = mmf_q;
	end

endmodule

`default_nettype wire

/* src/scc_decode.sv */
// ----------------------------------------------------------------------------
// scc_decode: access decoder of the system control register unit
// Decodes one coprocessor access, selects the read data, forms the status
// flags and cache maintenance pulses, and issues the register write.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_decode
	import scc_pkg::*;
(
	input  wire req_t      req,
	input  wire reg_view_t view,
	input  wire cfg_view_t cfg,
	output rsp_t           rsp,
	output reg_wr_t        wr
);

	logic              rd_hit;
	logic [WORD_W-1:0] rd_val;
	logic              rd_opc_err;
	logic              rd_ok;
	logic              wr_hit;
	logic              inv_i;
	logic              inv_d;
	logic              odd_fields;
	logic [WORD_W-1:0] control_next;

	assign odd_fields = (req.opc1 != 3'd0) || (req.secondary_reg != 4'd0);

	// Read side: which register is addressed and whether the opcode fields fit.
	always_comb begin
		rd_hit     = 1'b0;
		rd_val     = '0;
		rd_opc_err = 1'b0;
		rd_ok      = 1'b1;
		unique case (req.primary_reg)
			CRN_ID: begin
				rd_opc_err = (req.opc1 != 3'd0);
				if (req.secondary_reg == CRM_ID_MAIN) begin
					unique case (req.opc2)
						OPC2_0: begin rd_hit = 1'b1; rd_val = cfg.id_code; end
						OPC2_1: begin rd_hit = 1'b1; rd_val = cfg.cache_type; end
						OPC2_2: begin rd_hit = 1'b1; rd_val = TCM_STATUS; end
						OPC2_5: rd_hit = 1'b1;
						default: ;
					endcase
				end else if (req.secondary_reg == CRM_FEATURE && req.opc2[2]) begin
					rd_hit = 1'b1;
					rd_val = cfg.mem_model_feature[req.opc2[1:0]];
				end
			end
			CRN_CONTROL: begin
				rd_opc_err = odd_fields;
				if (req.opc2 == OPC2_0) begin
					rd_hit = 1'b1; rd_val = view.control_word;
				end else if (req.opc2 == OPC2_1) begin
					rd_hit = 1'b1; rd_val = view.aux_control_word;
				end
			end
			CRN_TTB: begin
				rd_opc_err = odd_fields;
				if (req.opc2 == OPC2_0) begin
					rd_hit = 1'b1; rd_val = view.table_base0;
				end
			end
			CRN_DOMAIN: begin
				rd_opc_err = odd_fields;
				if (req.opc2 == OPC2_0) begin
					rd_hit = 1'b1; rd_val = view.domain_word;
				end
			end
			CRN_FAULT_STATUS: begin
				rd_opc_err = odd_fields;
				if (req.opc2 == OPC2_0) begin
					rd_hit = 1'b1; rd_val = view.data_fault_status;
				end else if (req.opc2 == OPC2_1) begin
					rd_hit = 1'b1; rd_val = view.instr_fault_status;
				end
			end
			CRN_FAULT_ADDR: begin
				rd_opc_err = odd_fields;
				if (req.opc2 == OPC2_0) begin
					rd_hit = 1'b1; rd_val = view.fault_address;
				end
			end
			CRN_CACHE: begin
				// Clean and test-clean reads return zero; test-clean with opc2 3 reports Z.
				if (req.secondary_reg == CRM_CLEAN) begin
					rd_hit = 1'b1;
				end else if (req.secondary_reg == CRM_TEST_CLEAN) begin
					rd_hit = 1'b1;
					rd_ok  = (req.opc2 == OPC2_3);
				end
			end
			CRN_CONTEXT: begin
				rd_opc_err = odd_fields;
				for (int i = 0; i < CONTEXT_COUNT; i++) begin
					if (req.opc2 == CTX_IDX_W'(i)) begin
						rd_hit = 1'b1;
						rd_val = view.context_words[i];
					end
				end
			end
			default: ;
		endcase
	end

	// Write side: register stores and cache maintenance pulses.
	always_comb begin
		wr_hit     = 1'b0;
		inv_i      = 1'b0;
		inv_d      = 1'b0;
		wr.en      = 1'b0;
		wr.sel     = SEL_CONTROL;
		wr.ctx_idx = req.opc2;
		wr.data    = req.write_data;
		unique case (req.primary_reg)
			CRN_CONTROL: begin
				if (req.opc2 == OPC2_0) begin
					wr_hit = 1'b1; wr.sel = SEL_CONTROL;
				end else if (req.opc2 == OPC2_1) begin
					wr_hit = 1'b1; wr.sel = SEL_AUX;
				end
				wr.en = wr_hit;
			end
			CRN_TTB: begin
				if (req.opc2 == OPC2_0) begin
					wr_hit = 1'b1; wr.sel = SEL_TTB0;
				end else if (req.opc2 == OPC2_1) begin
					wr_hit = 1'b1; wr.sel = SEL_TTB1;
				end else if (req.opc2 == OPC2_2) begin
					wr_hit = 1'b1; wr.sel = SEL_TTBC;
				end
				wr.en = wr_hit;
			end
			CRN_DOMAIN: begin
				wr_hit = (req.opc2 == OPC2_0);
				wr.sel = SEL_DOMAIN;
				wr.en  = wr_hit;
			end
			CRN_FAULT_STATUS: begin
				if (req.opc2 == OPC2_0) begin
					wr_hit = 1'b1; wr.sel = SEL_DFSR;
				end else if (req.opc2 == OPC2_1) begin
					wr_hit = 1'b1; wr.sel = SEL_IFSR;
				end
				wr.en = wr_hit;
			end
			CRN_FAULT_ADDR: begin
				wr_hit = (req.opc2 == OPC2_0);
				wr.sel = SEL_FAR;
				wr.en  = wr_hit;
			end
			CRN_CACHE: begin
				if (req.secondary_reg == CRM_WFI) begin
					wr_hit = 1'b1;
				end else if (req.secondary_reg == CRM_INV_I) begin
					inv_i  = (req.opc2 <= OPC2_2);
					wr_hit = (req.opc2 != OPC2_3) && (req.opc2 != OPC2_5);
				end else if (req.secondary_reg == CRM_INV_D
						|| req.secondary_reg == CRM_TEST_CLEAN
						|| req.secondary_reg == CRM_CLEAN_INV) begin
					inv_d  = (req.opc2 <= OPC2_2);
					wr_hit = inv_d;
				end else if (req.secondary_reg == CRM_INV_BOTH) begin
					inv_i  = (req.opc2 == OPC2_0);
					inv_d  = inv_i;
					wr_hit = inv_i;
				end else if (req.secondary_reg == CRM_CLEAN) begin
					wr_hit = (req.opc2 != OPC2_3) && (req.opc2 < OPC2_6);
				end
			end
			CRN_TLB: begin
				wr_hit = (req.secondary_reg >= CRM_TLB_FIRST)
					&& (req.secondary_reg <= CRM_TLB_LAST);
			end
			CRN_CONTEXT: begin
				wr_hit = (req.opc2 < CTX_IDX_W'(CONTEXT_COUNT));
				wr.sel = SEL_CONTEXT;
				wr.en  = wr_hit;
			end
			default: ;
		endcase
		wr.en = wr.en && req.action;
	end

	// Control word as it stands after this access.
	assign control_next = (wr.en && wr.sel == SEL_CONTROL) ? req.write_data
		: view.control_word;

	// Result assembly.
	always_comb begin
		if (req.action) begin
			rsp.read_data         = '0;
			rsp.access_ok         = 1'b1;
			rsp.set_zero_flag     = 1'b0;
			rsp.access_error      = !wr_hit;
			rsp.invalidate_icache = inv_i;
			rsp.invalidate_dcache = inv_d;
		end else begin
			rsp.read_data         = rd_hit ? rd_val : '0;
			rsp.access_ok         = rd_ok;
			rsp.set_zero_flag     = rd_ok && (req.primary_reg == CRN_CACHE)
				&& (req.secondary_reg == CRM_TEST_CLEAN);
			rsp.access_error      = !rd_hit || rd_opc_err;
			rsp.invalidate_icache = 1'b0;
			rsp.invalidate_dcache = 1'b0;
		end
		rsp.mmu_on       = control_next[CTRL_MMU_BIT];
		rsp.icache_on    = control_next[CTRL_ICACHE_BIT];
		rsp.dcache_on    = control_next[CTRL_DCACHE_BIT];
		rsp.high_vectors = control_next[CTRL_HIVEC_BIT];
	end

endmodule

`default_nettype wire

/* src/system_control_coprocessor_regs_unit.sv */
// ----------------------------------------------------------------------------
// system_control_coprocessor_regs_unit: system control coprocessor registers
// Input register, access decode and register file, result register.
// ----------------------------------------------------------------------------
// One access can be accepted in every cycle unless the result side stalls:
// the input register feeds the decoder, whose result is captured in the
// output register while the register file is updated in the same cycle.
// An access sees every earlier access's writes. The user must write the
// configuration words through the cfg port only while no access is in
// flight; the block does not enforce this. A stall can hold two accesses.
// ----------------------------------------------------------------------------
`default_nettype none

module system_control_coprocessor_regs_unit
	import scc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire req_t                 req,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output rsp_t                      rsp,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WORD_W-1:0]    cfg_data
);

	logic      valid_s1;
	req_t      req_s1;
	logic      valid_s2;
	rsp_t      rsp_s2;
	logic      advance;
	reg_view_t view;
	cfg_view_t cfg;
	rsp_t      rsp_next;
	reg_wr_t   wr_cmd;
	reg_wr_t   wr_gated;

	// An access leaves the input register when the output register is free.
	assign advance   = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	// Decode against current register contents.
	scc_decode u_decode (
		.req  (req_s1),
		.view (view),
		.cfg  (cfg),
		.rsp  (rsp_next),
		.wr   (wr_cmd)
	);

	// Register state changes only when the access completes its pass.
	always_comb begin
		wr_gated    = wr_cmd;
		wr_gated.en = wr_cmd.en && advance;
	end

	scc_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr_gated),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.view      (view),
		.cfg       (cfg)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || rsp_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp_next;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

endmodule

`default_nettype wire

/* src/scc_checker.sv */
// ----------------------------------------------------------------------------
// scc_checker: port checks of the system control register unit
// Watches the result channel for held transfers and consistent flags, and the input side for readiness.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_checker
	import scc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp
);

	// A stalled result stays offered and unchanged.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// With no result waiting, the unit always takes a new transfer.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("input stalled with an empty result side");

	// A Z flag request is a successful, error-free access.
	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.set_zero_flag |-> rsp.access_ok && !rsp.access_error
		&& rsp.read_data == '0)
		else $error("Z flag with failed access");

	// Cache invalidation comes only from an error-free write, which reads zero.
	a_invalidate: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.invalidate_icache || rsp.invalidate_dcache)
		|-> !rsp.access_error && rsp.access_ok && rsp.read_data == '0
		&& !rsp.set_zero_flag)
		else $error("invalidation pulse on a bad access");

	// A failed test-clean read returns zero and no error.
	a_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.access_ok |-> rsp.read_data == '0
		&& !rsp.access_error && !rsp.set_zero_flag)
		else $error("failed access carries data or error");

endmodule

bind system_control_coprocessor_regs_unit scc_checker u_scc_checker (.*);

`default_nettype wire
